// ----- rtl/strs_pkg.sv -----
// ----------------------------------------------------------------------------
// Segment time range select: shared types and constants
// Table depth, field widths, operation and status codes, and the structs
// that pass between the sequencer and the multiply-divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

package strs_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IW          = $clog2(TABLE_DEPTH);
    localparam int CW          = $clog2(TABLE_DEPTH + 1);

    localparam int TIME_W  = 32;
    localparam int PTS_W   = 48;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 3;
    localparam int OIDX_W  = 6;

    localparam int PROD_W    = PTS_W + TIME_W;
    localparam int MUL_STEPS = TIME_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [STAT_W-1:0] ST_SEGMENT  = 3'd0;
    localparam logic [STAT_W-1:0] ST_APPENDED = 3'd1;
    localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_MATCH = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STAT_W-1:0] ST_BAD_SEG  = 3'd5;

    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic [PTS_W-1:0]  start_pts;
        logic [PTS_W-1:0]  end_pts;
    } t_entry;

    typedef struct packed {
        logic              start;
        logic [PTS_W-1:0]  d;
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
    } t_md_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [PTS_W-1:0] quot;
    } t_md_rsp;

endpackage

`default_nettype wire

// ----- rtl/strs_if.sv -----
// ----------------------------------------------------------------------------
// Segment time range select: channel interfaces
// Valid/ready channels for the operation word and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface strs_in_if;
    import strs_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [TIME_W-1:0]   seg_start_time;
    logic [TIME_W-1:0]   seg_end_time;
    logic [PTS_W-1:0]    seg_start_pts;
    logic [PTS_W-1:0]    seg_end_pts;
    logic [TIME_W-1:0]   query_start;
    logic [TIME_W-1:0]   query_end;

    modport source (output valid, operation, seg_start_time, seg_end_time,
                    seg_start_pts, seg_end_pts, query_start, query_end,
                    input ready);
    modport sink   (input valid, operation, seg_start_time, seg_end_time,
                    seg_start_pts, seg_end_pts, query_start, query_end,
                    output ready);
endinterface

interface strs_out_if;
    import strs_pkg::*;
    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [OIDX_W-1:0]   out_index;
    logic [TIME_W-1:0]   out_start_time;
    logic [TIME_W-1:0]   out_end_time;
    logic [PTS_W-1:0]    out_start_pts;
    logic [PTS_W-1:0]    out_end_pts;
    logic                last;

    modport source (output valid, status, out_index, out_start_time, out_end_time,
                    out_start_pts, out_end_pts, last, input ready);
    modport sink   (input valid, status, out_index, out_start_time, out_end_time,
                    out_start_pts, out_end_pts, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/segment_time_range_select.sv -----
// ----------------------------------------------------------------------------
// Segment time range select
// Keeps a table of recording segments and answers time window queries.
// ----------------------------------------------------------------------------
// i_in carries one operation word: clear, append or query. o_res carries the
// result words; the final word of each operation has last set.
// Clear and append give one word, valid from the edge after acceptance; the
// next operation can be taken once that word is in the output register.
// A query reads the table through one RAM read port, with a wait state for
// each read: two reads for the table ends, up to two binary searches of
// log2(depth) steps, a read of the right end, then one read per emitted segment.
// The first and last emitted segments may each be interpolated by the shared
// multiply-divide unit, and the query waits while it runs; an unused operation
// code gives no word.
// i_in.ready is high only while the sequencer is idle; a finished word sits
// in the output register, so the next operation is taken while it waits.
// If the receiver stalls, the sequencer holds before loading the next word.
// Reset empties the table; stored entries are not cleared, only the count.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_time_range_select (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    strs_in_if.sink     i_in,
    strs_out_if.source  o_res
);
    import strs_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_WAIT   = 4'd1;
    localparam logic [3:0] S_CLAST  = 4'd2;
    localparam logic [3:0] S_CFIRST = 4'd3;
    localparam logic [3:0] S_BL     = 4'd4;
    localparam logic [3:0] S_RIGHT  = 4'd5;
    localparam logic [3:0] S_BR     = 4'd6;
    localparam logic [3:0] S_EQ     = 4'd7;
    localparam logic [3:0] S_CEQ    = 4'd8;
    localparam logic [3:0] S_ELOAD  = 4'd9;
    localparam logic [3:0] S_IP0    = 4'd10;
    localparam logic [3:0] S_CHK1   = 4'd11;
    localparam logic [3:0] S_IP1    = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;
    localparam logic [3:0] S_RES    = 4'd14;

    logic [3:0]        r_state, n_state;
    logic [3:0]        r_ret, n_ret;
    logic [CW-1:0]     r_count, n_count;
    logic [IW-1:0]     r_raddr, n_raddr;
    logic [TIME_W-1:0] r_qs, n_qs;
    logic [TIME_W-1:0] r_qe, n_qe;
    logic [TIME_W-1:0] r_elast, n_elast;
    logic [TIME_W-1:0] r_s0, n_s0;
    logic [IW-1:0]     r_lidx, n_lidx;
    logic [IW-1:0]     r_ridx, n_ridx;
    logic [IW-1:0]     r_lo, n_lo;
    logic [IW-1:0]     r_hi, n_hi;
    logic [IW-1:0]     r_i, n_i;
    logic [TIME_W-1:0] r_s, n_s;
    logic [TIME_W-1:0] r_e, n_e;
    logic [PTS_W-1:0]  r_p0, n_p0;
    logic [PTS_W-1:0]  r_p1, n_p1;
    logic [STAT_W-1:0] r_pst, n_pst;
    logic [IW-1:0]     r_pidx, n_pidx;

    logic              r_ovalid;
    logic [STAT_W-1:0] r_ostat;
    logic [IW-1:0]     r_oidx;
    logic [TIME_W-1:0] r_os, r_oe;
    logic [PTS_W-1:0]  r_op0, r_op1;
    logic              r_olast;

    logic              load, load_seg, out_free, accept, we;
    logic [IW-1:0]     mid, lo_nx, hi_nx, last_idx;
    logic [IW+OIDX_W-1:0] idx_ext;
    t_entry            rd, wd;
    t_md_req           md_req;
    t_md_rsp           md_rsp;

    strs_ram #(.WIDTH($bits(t_entry)), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (wd),
        .i_raddr (r_raddr),
        .o_rdata (rd)
    );

    strs_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    assign out_free    = !r_ovalid || o_res.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign accept      = i_in.valid && i_in.ready;
    assign last_idx    = IW'(r_count - CW'(1));
    assign mid         = r_lo + IW'((r_hi - r_lo) >> 1);

    assign wd.start_time = i_in.seg_start_time;
    assign wd.end_time   = i_in.seg_end_time;
    assign wd.start_pts  = i_in.seg_start_pts;
    assign wd.end_pts    = i_in.seg_end_pts;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_count = r_count;
        n_raddr = r_raddr;
        n_qs    = r_qs;
        n_qe    = r_qe;
        n_elast = r_elast;
        n_s0    = r_s0;
        n_lidx  = r_lidx;
        n_ridx  = r_ridx;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_i     = r_i;
        n_s     = r_s;
        n_e     = r_e;
        n_p0    = r_p0;
        n_p1    = r_p1;
        n_pst   = r_pst;
        n_pidx  = r_pidx;
        lo_nx   = r_lo;
        hi_nx   = r_hi;
        we      = 1'b0;
        load    = 1'b0;
        load_seg = 1'b0;
        md_req.start = 1'b0;
        md_req.d     = r_p1 - r_p0;
        md_req.a     = r_qs - r_s;
        md_req.b     = r_e - r_s;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pidx = '0;
                    n_qs   = i_in.query_start;
                    n_qe   = i_in.query_end;
                    case (i_in.operation)
                        OP_CLEAR: begin
                            n_count = '0;
                            n_pst   = ST_CLEARED;
                            n_state = S_RES;
                        end
                        OP_APPEND: begin
                            n_state = S_RES;
                            if (r_count >= CW'(TABLE_DEPTH)) begin
                                n_pst = ST_FULL;
                            end else if (i_in.seg_end_pts < i_in.seg_start_pts) begin
                                n_pst = ST_BAD_SEG;
                            end else begin
                                we      = 1'b1;
                                n_count = r_count + CW'(1);
                                n_pst   = ST_APPENDED;
                                n_pidx  = r_count[IW-1:0];
                            end
                        end
                        OP_QUERY: begin
                            if (i_in.query_start > i_in.query_end || r_count == '0) begin
                                n_pst   = ST_NO_MATCH;
                                n_state = S_RES;
                            end else begin
                                n_raddr = last_idx;
                                n_ret   = S_CLAST;
                                n_state = S_WAIT;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_WAIT: begin
                n_state = r_ret;
            end
            S_CLAST: begin
                n_elast = rd.end_time;
                if (rd.end_time <= r_qs) begin
                    n_pst   = ST_NO_MATCH;
                    n_state = S_RES;
                end else begin
                    n_raddr = '0;
                    n_ret   = S_CFIRST;
                    n_state = S_WAIT;
                end
            end
            S_CFIRST: begin
                n_s0 = rd.start_time;
                if (rd.start_time >= r_qs) begin
                    n_lidx  = '0;
                    n_state = S_RIGHT;
                end else begin
                    n_lo    = '0;
                    n_hi    = last_idx;
                    n_raddr = IW'(last_idx >> 1);
                    n_ret   = S_BL;
                    n_state = S_WAIT;
                end
            end
            S_BL: begin
                if (rd.start_time <= r_qs && rd.end_time > r_qs) begin
                    n_lidx  = mid;
                    n_state = S_RIGHT;
                end else if (mid == r_lo) begin
                    n_lidx  = (rd.end_time < r_qs) ? r_hi : mid;
                    n_state = S_RIGHT;
                end else begin
                    if (rd.start_time < r_qs) begin
                        lo_nx = mid + IW'(1);
                    end else begin
                        hi_nx = mid;
                    end
                    n_lo    = lo_nx;
                    n_hi    = hi_nx;
                    n_raddr = lo_nx + IW'((hi_nx - lo_nx) >> 1);
                    n_ret   = S_BL;
                    n_state = S_WAIT;
                end
            end
            S_RIGHT: begin
                if (r_elast <= r_qe) begin
                    n_ridx  = last_idx;
                    n_state = S_EQ;
                end else if (r_s0 >= r_qe) begin
                    n_pst   = ST_NO_MATCH;
                    n_state = S_RES;
                end else begin
                    n_lo    = r_lidx;
                    n_hi    = last_idx;
                    n_raddr = r_lidx + IW'((last_idx - r_lidx) >> 1);
                    n_ret   = S_BR;
                    n_state = S_WAIT;
                end
            end
            S_BR: begin
                if (rd.start_time <= r_qe && rd.end_time > r_qe) begin
                    n_ridx  = mid;
                    n_state = S_EQ;
                end else if (mid == r_lo) begin
                    n_ridx  = (rd.start_time < r_qe) ? r_hi : mid;
                    n_state = S_EQ;
                end else begin
                    if (rd.end_time <= r_qe) begin
                        lo_nx = mid;
                    end else begin
                        hi_nx = mid - IW'(1);
                    end
                    n_lo    = lo_nx;
                    n_hi    = hi_nx;
                    n_raddr = lo_nx + IW'((hi_nx - lo_nx) >> 1);
                    n_ret   = S_BR;
                    n_state = S_WAIT;
                end
            end
            S_EQ: begin
                n_raddr = r_ridx;
                n_ret   = S_CEQ;
                n_state = S_WAIT;
            end
            S_CEQ: begin
                n_i     = r_lidx;
                n_raddr = r_lidx;
                n_ret   = S_ELOAD;
                n_state = S_WAIT;
                if (r_ridx == r_lidx) begin
                    if (rd.start_time > r_qe || rd.end_time < r_qs) begin
                        n_pst   = ST_NO_MATCH;
                        n_state = S_RES;
                    end
                end else if (rd.start_time == r_qe) begin
                    n_ridx = r_ridx - IW'(1);
                end
            end
            S_ELOAD: begin
                n_s  = rd.start_time;
                n_e  = rd.end_time;
                n_p0 = rd.start_pts;
                n_p1 = rd.end_pts;
                if (r_i == r_lidx && rd.start_time < r_qs && rd.end_time > r_qs) begin
                    md_req.start = 1'b1;
                    md_req.d     = rd.end_pts - rd.start_pts;
                    md_req.a     = r_qs - rd.start_time;
                    md_req.b     = rd.end_time - rd.start_time;
                    n_state      = S_IP0;
                end else begin
                    n_state = S_CHK1;
                end
            end
            S_IP0: begin
                if (md_rsp.done) begin
                    n_p0    = r_p0 + md_rsp.quot;
                    n_state = S_CHK1;
                end
            end
            S_CHK1: begin
                if (r_i == r_ridx && r_s < r_qe && r_e > r_qe) begin
                    md_req.start = 1'b1;
                    md_req.a     = r_qe - r_s;
                    n_state      = S_IP1;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_IP1: begin
                if (md_rsp.done) begin
                    n_p1    = r_p0 + md_rsp.quot;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    load_seg = 1'b1;
                    if (r_i == r_ridx) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + IW'(1);
                        n_raddr = r_i + IW'(1);
                        n_ret   = S_ELOAD;
                        n_state = S_WAIT;
                    end
                end
            end
            S_RES: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_count <= n_count;
            if (load || load_seg) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_raddr <= n_raddr;
        r_qs    <= n_qs;
        r_qe    <= n_qe;
        r_elast <= n_elast;
        r_s0    <= n_s0;
        r_lidx  <= n_lidx;
        r_ridx  <= n_ridx;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_i     <= n_i;
        r_s     <= n_s;
        r_e     <= n_e;
        r_p0    <= n_p0;
        r_p1    <= n_p1;
        r_pst   <= n_pst;
        r_pidx  <= n_pidx;
        if (load_seg) begin
            r_ostat <= ST_SEGMENT;
            r_oidx  <= r_i;
            r_os    <= r_s;
            r_oe    <= r_e;
            r_op0   <= r_p0;
            r_op1   <= r_p1;
            r_olast <= (r_i == r_ridx);
        end else if (load) begin
            r_ostat <= r_pst;
            r_oidx  <= r_pidx;
            r_os    <= '0;
            r_oe    <= '0;
            r_op0   <= '0;
            r_op1   <= '0;
            r_olast <= 1'b1;
        end
    end

    assign idx_ext = (IW + OIDX_W)'(r_oidx);

    assign o_res.valid          = r_ovalid;
    assign o_res.status         = r_ostat;
    assign o_res.out_index      = idx_ext[OIDX_W-1:0];
    assign o_res.out_start_time = r_os;
    assign o_res.out_end_time   = r_oe;
    assign o_res.out_start_pts  = r_op0;
    assign o_res.out_end_pts    = r_op1;
    assign o_res.last           = r_olast;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_idle_unit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !md_rsp.busy)
        else $error("multiply-divide unit busy while idle");

    a_done_awaited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_rsp.done |-> (r_state == S_IP0 || r_state == S_IP1))
        else $error("interpolation finished with nobody waiting");

    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_i >= r_lidx && r_i <= r_ridx))
        else $error("emitted index outside the selected range");

endmodule

`default_nettype wire

// ----- rtl/strs_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module strs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/strs_muldiv.sv -----
// ----------------------------------------------------------------------------
// Segment time range select: shift-add multiply, restoring divide
// Computes floor(d * a / b) one bit per cycle: a multiply phase of one step
// per bit of a, then a divide phase of one step per bit of the product.
// ----------------------------------------------------------------------------
`default_nettype none

module strs_muldiv (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire strs_pkg::t_md_req i_req,
    output      strs_pkg::t_md_rsp o_rsp
);
    import strs_pkg::*;

    logic               r_busy;
    logic               r_div;
    logic               r_done;
    logic [STEP_W-1:0]  r_cnt;
    logic [PROD_W-1:0]  r_acc;
    logic [TIME_W-1:0]  r_rem;
    logic [TIME_W-1:0]  r_a;
    logic [TIME_W-1:0]  r_b;
    logic [PTS_W-1:0]   r_d;

    logic [PROD_W-1:0]  mul_acc;
    logic [TIME_W:0]    trial;
    logic               qbit;

    always_comb begin
        mul_acc = {r_acc[PROD_W-2:0], 1'b0} + (r_a[TIME_W-1] ? PROD_W'(r_d) : '0);
        trial   = {r_rem, r_acc[PROD_W-1]};
        qbit    = (trial >= {1'b0, r_b});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_div  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_div  <= 1'b0;
                r_cnt  <= STEP_W'(MUL_STEPS);
            end else if (r_busy) begin
                if (r_cnt == STEP_W'(1)) begin
                    if (!r_div) begin
                        r_div <= 1'b1;
                        r_cnt <= STEP_W'(DIV_STEPS);
                    end else begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end else begin
                    r_cnt <= r_cnt - STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_acc <= '0;
            r_rem <= '0;
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_d   <= i_req.d;
        end else if (r_busy && !r_div) begin
            r_acc <= mul_acc;
            r_a   <= {r_a[TIME_W-2:0], 1'b0};
        end else if (r_busy) begin
            // The remainder stays below b, so it always fits the time width.
            r_rem <= qbit ? TIME_W'(trial - {1'b0, r_b}) : trial[TIME_W-1:0];
            r_acc <= {r_acc[PROD_W-2:0], qbit};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_acc[PTS_W-1:0];

endmodule

`default_nettype wire
